### rtl/advs_pkg.sv
// Shared types and constants for the advection stencil row stepper.
// Used by the top, front, queue and back modules; depends on nothing else.
package advs_pkg;

  // Field widths of the payload
  localparam int DATA_W    = 32;
  localparam int COLUMN_W  = 10;
  localparam int FRAC_W    = 16;

  // Arithmetic widths: one product, the exact sum of five products, the sum after scaling
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 3;
  localparam int SHIFT_W   = SUM_W - FRAC_W;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_SOURCE     = 3'd0,
    CFG_COEF_PREV_LEFT  = 3'd1,
    CFG_COEF_PREV_MID   = 3'd2,
    CFG_COEF_PREV_RIGHT = 3'd3,
    CFG_COEF_NEW_LEFT   = 3'd4
  } cfg_reg_t;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Reset value of the middle weight: 1.0 in Q16.16
  localparam logic signed [DATA_W-1:0] COEF_MID_RESET = 32'sd65536;

  // Half an output LSB, added before the floor shift
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (FRAC_W - 1));

  // Saturation limits at the width of the scaled sum
  localparam logic signed [SHIFT_W-1:0] SAT_MAX =
    {{(SHIFT_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SHIFT_W-1:0] SAT_MIN =
    {{(SHIFT_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // Input beat
  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] source;
    logic                     last_in_row;
  } req_t;

  // Output beat
  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic [COLUMN_W-1:0]      column;
    logic                     row_end;
  } rsp_t;

  // The five weights
  typedef struct packed {
    logic signed [DATA_W-1:0] source;
    logic signed [DATA_W-1:0] prev_left;
    logic signed [DATA_W-1:0] prev_mid;
    logic signed [DATA_W-1:0] prev_right;
    logic signed [DATA_W-1:0] new_left;
  } coef_t;

  // A classified item as it travels from the front to the back
  typedef struct packed {
    logic                     step;        // step item, reads the stored middle value
    logic                     use_sum;     // step away from column zero, result is the sum
    logic                     need_right;  // sum needs the stored right neighbor
    logic                     closes;      // item ends the row
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] source;
  } op_t;

  // Sign-extend one product to the width of the accumulated sum
  function automatic logic signed [SUM_W-1:0] sext_prod(input logic signed [PROD_W-1:0] p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

### rtl/advection_stencil_row_step.sv
// Top level of the advection stencil row stepper: weight registers, front, queue, back.
// Depends on advs_pkg, advs_front, advs_queue and advs_back.
//
//   channel   signals                             beat
//   -------   ---------------------------------   --------------------------------------
//   req       req_valid, req_ready, req           one load or step item
//   rsp       rsp_valid, rsp_ready, rsp           one stored value per item
//   cfg       cfg_valid, cfg_ready, cfg_index,    one weight write, always ready
//             cfg_data
//
// One item per cycle is sustained while rsp is ready and no step waits as described below.
// A step away from column zero waits while a step is in the last stage and the new-row
// weight is nonzero: the new-row neighbor loops through a multiplier and the rounding stage.
// A step whose store columns are still being written waits for the write; this occurs only
// just after a row shorter than five columns. Reset is synchronous; the row store is not
// cleared and holds nothing defined until loaded. When rsp stalls, the output register,
// three pipeline stages and a four-entry queue fill before req_ready drops.
module advection_stencil_row_step
  import advs_pkg::*;
#(
  parameter int ROW_LENGTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int COL_W = $clog2(ROW_LENGTH);

  coef_t            coef;
  logic             q_full;
  logic             push;
  op_t              push_op;
  logic [COL_W-1:0] push_col;
  logic             pop;
  logic             head_valid;
  op_t              head_op;
  logic [COL_W-1:0] head_col;

  // Weight registers; writes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.source     <= '0;
      coef.prev_left  <= '0;
      coef.prev_mid   <= COEF_MID_RESET;
      coef.prev_right <= '0;
      coef.new_left   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COEF_SOURCE:     coef.source     <= $signed(cfg_data);
        CFG_COEF_PREV_LEFT:  coef.prev_left  <= $signed(cfg_data);
        CFG_COEF_PREV_MID:   coef.prev_mid   <= $signed(cfg_data);
        CFG_COEF_PREV_RIGHT: coef.prev_right <= $signed(cfg_data);
        CFG_COEF_NEW_LEFT:   coef.new_left   <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  advs_front #(
    .ROW_LENGTH (ROW_LENGTH),
    .COL_W      (COL_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op),
    .push_col  (push_col)
  );

  advs_queue #(
    .COL_W (COL_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .push_col   (push_col),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .head_col   (head_col)
  );

  advs_back #(
    .ROW_LENGTH (ROW_LENGTH),
    .COL_W      (COL_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .head_valid (head_valid),
    .head_op    (head_op),
    .head_col   (head_col),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

### rtl/advs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the row store.
module advs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/advs_front.sv
// Front end: accepts input beats, tracks the column and classifies each item.
// Depends on advs_pkg.
module advs_front
  import advs_pkg::*;
#(
  parameter int ROW_LENGTH = 1024,
  parameter int COL_W      = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  input  logic             q_full,
  output logic             push,
  output op_t              push_op,
  output logic [COL_W-1:0] push_col
);

  logic [COL_W-1:0] column_counter;
  logic [COL_W-1:0] column_counter_next;
  logic             at_last;
  logic             closes;

  // Accept whenever the queue has room.
  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;

  // A row ends on the marker or at the last column of the store.
  assign at_last = column_counter == COL_W'(ROW_LENGTH - 1);
  assign closes  = req.last_in_row || at_last;

  // Classify the item for the back end.
  always_comb begin
    push_op.step       = req.cmd == CMD_STEP;
    push_op.use_sum    = push_op.step && (column_counter != '0);
    push_op.need_right = push_op.use_sum && !closes;
    push_op.closes     = closes;
    push_op.value      = req.value;
    push_op.source     = req.source;
  end
  assign push_col = column_counter;

  // Column counter.
  assign column_counter_next = closes ? '0 : column_counter + COL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
    end else if (push) begin
      column_counter <= column_counter_next;
    end
  end

endmodule

### rtl/advs_queue.sv
// Short queue of classified items between the front and the back.
// Depends on advs_pkg.
module advs_queue
  import advs_pkg::*;
#(
  parameter int COL_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  op_t              push_op,
  input  logic [COL_W-1:0] push_col,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output op_t              head_op,
  output logic [COL_W-1:0] head_col
);

  op_t              entry_op  [QUEUE_DEPTH];
  logic [COL_W-1:0] entry_col [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = entry_op[rd_ptr];
  assign head_col   = entry_col[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_op[wr_ptr]  <= push_op;
      entry_col[wr_ptr] <= push_col;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

### rtl/advs_back.sv
// Back end: row store reads, weighted sum pipeline, store write-back and output register.
// Depends on advs_pkg and advs_ram.
module advs_back
  import advs_pkg::*;
#(
  parameter int ROW_LENGTH = 1024,
  parameter int COL_W      = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  coef_t            coef,
  input  logic             head_valid,
  input  op_t              head_op,
  input  logic [COL_W-1:0] head_col,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  // Stage registers
  logic             s1_valid, s2_valid, s3_valid;
  op_t              s1_op, s2_op, s3_op;
  logic [COL_W-1:0] s1_col, s2_col, s3_col;
  logic signed [PROD_W-1:0] s2_prod_source, s2_prod_left, s2_prod_mid, s2_prod_right;
  logic signed [SUM_W-1:0]  s3_psum;
  logic signed [PROD_W-1:0] s3_pnl;

  // Neighbor state carried from one step to the next
  logic signed [DATA_W-1:0] held_prev_left;
  logic signed [DATA_W-1:0] new_left_value;

  // Handshake between stages
  logic s1_go, s2_go, s3_go;
  logic s1_free, s2_free, s3_free;
  logic dep_stall;

  // Store access
  logic [COL_W-1:0]  right_col;
  logic              mid_hit, right_hit;
  logic [DATA_W-1:0] mid_rd, right_rd;
  logic signed [DATA_W-1:0] mid, right;

  // Arithmetic
  logic signed [SUM_W-1:0]   psum;
  logic signed [PROD_W-1:0]  pnl;
  logic signed [SUM_W-1:0]   total;
  logic signed [SHIFT_W-1:0] scaled;
  logic signed [DATA_W-1:0]  sat;
  logic signed [DATA_W-1:0]  s3_result;

  // Stage advance, from the output back to the queue head.
  assign s3_go   = s3_valid && (!rsp_valid || rsp_ready);
  assign s3_free = !s3_valid || s3_go;
  assign dep_stall = s2_op.use_sum && (coef.new_left != '0) && s3_valid && s3_op.step;
  assign s2_go   = s2_valid && s3_free && !dep_stall;
  assign s2_free = !s2_valid || s2_go;
  assign s1_go   = s1_valid && s2_free;
  assign s1_free = !s1_valid || s1_go;

  // A step reads only after every in-flight write to its columns has landed.
  assign right_col = head_col + COL_W'(1);
  assign mid_hit = head_op.step &&
                   ((s1_valid && s1_col == head_col) ||
                    (s2_valid && s2_col == head_col) ||
                    (s3_valid && s3_col == head_col));
  assign right_hit = head_op.need_right &&
                     ((s1_valid && s1_col == right_col) ||
                      (s2_valid && s2_col == right_col) ||
                      (s3_valid && s3_col == right_col));
  assign pop = head_valid && s1_free && !mid_hit && !right_hit;

  // Two copies of the row store, written together, read at the column and the next one.
  advs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROW_LENGTH)
  ) u_ram_mid (
    .clk   (clk),
    .we    (s3_go),
    .waddr (s3_col),
    .wdata (s3_result),
    .re    (pop),
    .raddr (head_col),
    .rdata (mid_rd)
  );

  advs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROW_LENGTH)
  ) u_ram_right (
    .clk   (clk),
    .we    (s3_go),
    .waddr (s3_col),
    .wdata (s3_result),
    .re    (pop),
    .raddr (right_col),
    .rdata (right_rd)
  );

  // Stage 1: store data in hand; at the row end the middle value stands in on the right.
  assign mid   = $signed(mid_rd);
  assign right = s1_op.closes ? $signed(mid_rd) : $signed(right_rd);

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op  <= head_op;
      s1_col <= head_col;
    end
  end

  // Stage 1 to 2: four products that do not depend on the new row.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_op          <= s1_op;
      s2_col         <= s1_col;
      s2_prod_source <= $signed(coef.source) * $signed(s1_op.source);
      s2_prod_left   <= $signed(coef.prev_left) * $signed(held_prev_left);
      s2_prod_mid    <= $signed(coef.prev_mid) * $signed(mid);
      s2_prod_right  <= $signed(coef.prev_right) * $signed(right);
    end
  end

  // Left neighbor of the previous row: the middle value of the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_prev_left <= '0;
    end else if (s1_go && s1_op.step) begin
      held_prev_left <= mid;
    end
  end

  // Stage 2: partial sum, and the new-row product from the last step's result.
  assign psum = sext_prod(s2_prod_source) + sext_prod(s2_prod_left) +
                sext_prod(s2_prod_mid) + sext_prod(s2_prod_right);
  assign pnl  = $signed(coef.new_left) * $signed(new_left_value);

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_op   <= s2_op;
      s3_col  <= s2_col;
      s3_psum <= psum;
      s3_pnl  <= pnl;
    end
  end

  // Stage 3: round half up, scale, saturate, and pick the result.
  assign total  = s3_psum + sext_prod(s3_pnl) + ROUND_HALF;
  assign scaled = $signed(total[SUM_W-1:FRAC_W]);

  always_comb begin
    if (scaled > SAT_MAX) begin
      sat = $signed(SAT_MAX[DATA_W-1:0]);
    end else if (scaled < SAT_MIN) begin
      sat = $signed(SAT_MIN[DATA_W-1:0]);
    end else begin
      sat = $signed(scaled[DATA_W-1:0]);
    end
  end

  assign s3_result = s3_op.use_sum ? sat : s3_op.value;

  // New-row left neighbor: the result of the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      new_left_value <= '0;
    end else if (s3_go && s3_op.step) begin
      new_left_value <= s3_result;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop;
      end
      if (s2_free) begin
        s2_valid <= s1_go;
      end
      if (s3_free) begin
        s3_valid <= s2_go;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s3_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      rsp.result  <= s3_result;
      rsp.column  <= COLUMN_W'(s3_col);
      rsp.row_end <= s3_op.closes;
    end
  end

`ifndef SYNTHESIS
  // No write lands on a column that a younger step has already read.
  a_mid_fresh_s1: assert property (@(posedge clk) disable iff (rst)
    s3_go && s1_valid && s1_op.step |-> s3_col != s1_col)
    else $error("row store write overtakes the middle read in stage 1");

  a_mid_fresh_s2: assert property (@(posedge clk) disable iff (rst)
    s3_go && s2_valid && s2_op.step |-> s3_col != s2_col)
    else $error("row store write overtakes the middle read in stage 2");

  a_right_fresh: assert property (@(posedge clk) disable iff (rst)
    s3_go && s1_valid && s1_op.need_right |-> s3_col != s1_col + COL_W'(1))
    else $error("row store write overtakes the right read");

  // A sum that uses the new-row neighbor never passes a step whose result is pending.
  a_new_left_order: assert property (@(posedge clk) disable iff (rst)
    s2_go && s2_op.use_sum && coef.new_left != '0 |-> !(s3_valid && s3_op.step))
    else $error("new-row neighbor used before the previous step retired");
`endif

endmodule

### tb/testbench.sv
// Self-checking bench for advection_stencil_row_step: drives load and step beats, predicts
// every stored grid point with its own stencil model and compares each response beat.
// Depends on advs_pkg and the RTL of the row stepper.

// Predicts the stored point for every accepted request beat and checks response beats.
class stencil_row_model #(int ROW_LEN = 1024);
  logic signed [31:0] weight [5];
  logic signed [31:0] row_store [ROW_LEN];
  int unsigned col_count;
  logic signed [31:0] old_left;
  logic signed [31:0] new_left;
  advs_pkg::rsp_t expected_points [$];
  int unsigned mismatches;

  function new();
    foreach (weight[k]) begin
      weight[k] = '0;
    end
    weight[advs_pkg::CFG_COEF_PREV_MID] = advs_pkg::COEF_MID_RESET;
    col_count = 0;
    old_left = '0;
    new_left = '0;
    mismatches = 0;
  endfunction

  function void write_weight(advs_pkg::cfg_reg_t idx, logic [31:0] data);
    if (idx <= advs_pkg::CFG_COEF_NEW_LEFT) begin
      weight[idx] = data;
    end
  endfunction

  // Exact sum of the five products, rounded half up to Q16.16 and saturated.
  function logic signed [31:0] stencil_point(logic signed [31:0] src, logic signed [31:0] l,
                                             logic signed [31:0] m, logic signed [31:0] r,
                                             logic signed [31:0] nl);
    logic signed [31:0] term [5];
    logic signed [79:0] lhs;
    logic signed [79:0] rhs;
    logic signed [79:0] acc;
    // Terms follow the order of the weight register indexes.
    term = '{src, l, m, r, nl};
    acc = 80'sd32768;
    for (int k = 0; k < 5; k++) begin
      lhs = weight[k];
      rhs = term[k];
      acc = acc + lhs * rhs;
    end
    acc = acc >>> 16;
    if (acc > 80'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (acc < -80'sd2147483648) begin
      return 32'h8000_0000;
    end
    return acc[31:0];
  endfunction

  function void note_item(advs_pkg::req_t item);
    advs_pkg::rsp_t point;
    int unsigned col;
    logic closes;
    logic signed [31:0] mid;
    logic signed [31:0] right;
    logic signed [31:0] res;
    col = col_count % ROW_LEN;
    closes = item.last_in_row || col == ROW_LEN - 1;
    if (item.cmd == advs_pkg::CMD_LOAD) begin
      res = item.value;
    end else begin
      mid = row_store[col];
      if (col == 0) begin
        res = item.value;
      end else begin
        // At the row end the middle value stands in for the missing right neighbor.
        right = closes ? mid : row_store[col + 1];
        res = stencil_point(item.source, old_left, mid, right, new_left);
      end
      old_left = mid;
      new_left = res;
    end
    row_store[col] = res;
    point.result = res;
    point.column = col[advs_pkg::COLUMN_W-1:0];
    point.row_end = closes;
    expected_points.push_back(point);
    col_count = closes ? 0 : col + 1;
  endfunction

  function void check_result(advs_pkg::rsp_t got);
    advs_pkg::rsp_t want;
    if (expected_points.size() == 0) begin
      $error("response beat with no point pending: result %0d column %0d",
             got.result, got.column);
      mismatches++;
      return;
    end
    want = expected_points.pop_front();
    if (got.result !== want.result) begin
      $error("result: expected %0d, got %0d", want.result, got.result);
      mismatches++;
    end
    if (got.column !== want.column) begin
      $error("column: expected %0d, got %0d", want.column, got.column);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_points.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import advs_pkg::*;

  localparam int ROW_LEN      = 1024;
  localparam int IDLE_PCT     = 12;
  localparam int RANDOM_ITEMS = 250;
  localparam int ROW_MAX      = 12;
  // Handshake-free cycles far beyond the longest random stall or drain pause.
  localparam int STALL_LIMIT  = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COEF_SOURCE;
  logic [DATA_W-1:0]    cfg_data = '0;

  stencil_row_model #(ROW_LEN) model;
  bit          written [ROW_LEN];
  int unsigned gen_col = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  bit          steady = 1'b0;

  advection_stencil_row_step #(.ROW_LENGTH(ROW_LEN)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Sample every channel at the rising edge and feed the model.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (req_valid && req_ready) begin
        model.note_item(req);
      end
      if (rsp_valid && rsp_ready) begin
        model.check_result(rsp);
      end
      if (cfg_valid && cfg_ready) begin
        model.write_weight(cfg_reg_t'(cfg_index), cfg_data);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Response side back-pressure.
  always @(negedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Send one request beat. A step that would read an unloaded store column becomes a load.
  task automatic send_point(input logic cmd, input logic [31:0] value,
                            input logic [31:0] source, input logic last);
    req_t item;
    logic closes;
    closes = last || gen_col == ROW_LEN - 1;
    item.cmd = cmd;
    item.value = value;
    item.source = source;
    item.last_in_row = last;
    if (cmd == CMD_STEP && (!written[gen_col] ||
        (gen_col != 0 && !closes && !written[gen_col + 1]))) begin
      item.cmd = CMD_LOAD;
    end
    written[gen_col] = 1'b1;
    gen_col = closes ? 0 : gen_col + 1;
    items_sent++;
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // Hold the sender until every pending point has come back.
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (model.pending() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_weights(input coef_t w);
    write_reg(CFG_COEF_SOURCE, w.source);
    write_reg(CFG_COEF_PREV_LEFT, w.prev_left);
    write_reg(CFG_COEF_PREV_MID, w.prev_mid);
    write_reg(CFG_COEF_PREV_RIGHT, w.prev_right);
    write_reg(CFG_COEF_NEW_LEFT, w.new_left);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Grid samples: full range, small and moderate magnitudes, and the extremes.
  function automatic logic [31:0] rand_sample();
    int offset;
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        offset = int'($urandom_range(2097152)) - 1048576;
        return offset;
      end
      2: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        offset = int'($urandom_range(33554432)) - 16777216;
        return offset;
      end
    endcase
  endfunction

  // Weights: typical scheme values, small fractions, zero and the full range.
  function automatic logic [31:0] rand_weight();
    int offset;
    case ($urandom_range(5))
      0: return 32'h0001_0000;
      1: return 32'h0000_8000;
      2: return 32'hFFFF_8000;
      3: begin
        offset = int'($urandom_range(262144)) - 131072;
        return offset;
      end
      4: return $urandom();
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic coef_t random_weights();
    coef_t w;
    w.source = rand_weight();
    w.prev_left = rand_weight();
    w.prev_mid = rand_weight();
    w.prev_right = rand_weight();
    w.new_left = rand_weight();
    return w;
  endfunction

  // One row: mostly loads followed by well-formed step rows, sometimes mixed noise.
  task automatic random_row();
    int unsigned kind;
    int unsigned len;
    int unsigned prefix;
    kind = $urandom_range(9);
    prefix = 0;
    while (prefix < ROW_LEN && written[prefix]) begin
      prefix++;
    end
    if (kind < 3 || prefix == 0) begin
      len = $urandom_range(1, ROW_MAX);
      for (int i = 0; i < len; i++) begin
        send_point(CMD_LOAD, rand_sample(), rand_sample(), i == len - 1);
      end
    end else if (kind < 8) begin
      len = $urandom_range(1, prefix < ROW_MAX ? prefix : ROW_MAX);
      for (int i = 0; i < len; i++) begin
        send_point(CMD_STEP, rand_sample(), rand_sample(), i == len - 1);
      end
    end else begin
      len = $urandom_range(1, ROW_MAX);
      for (int i = 0; i < len; i++) begin
        send_point($urandom_range(1) ? CMD_STEP : CMD_LOAD, rand_sample(), rand_sample(),
                   $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned phase_end;
    model = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset weights pass the stored row through; a load closes the first row.
    send_point(CMD_LOAD, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_point(CMD_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(CMD_LOAD, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
    send_point(CMD_LOAD, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    // Boundary value at column zero, then a load in the middle of a step row.
    send_point(CMD_STEP, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(CMD_LOAD, 32'h0001_0000, 32'h0000_0000, 1'b0);
    send_point(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

    // All weights at the negative extreme: the sums saturate.
    drain_results();
    program_weights('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000});
    send_point(CMD_STEP, 32'h0000_0000, 32'h8000_0000, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h8000_0000, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);

    // All weights at the positive extreme.
    drain_results();
    program_weights('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF});
    send_point(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h8000_0000, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);

    // Half weight on the middle only: exact ties round toward plus infinity.
    drain_results();
    program_weights('{32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000,
                      32'h0000_0000});
    send_point(CMD_LOAD, 32'h0000_0001, 32'h0000_0000, 1'b0);
    send_point(CMD_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_point(CMD_LOAD, 32'h0000_0001, 32'h0000_0000, 1'b0);
    send_point(CMD_LOAD, 32'h0000_0003, 32'h0000_0000, 1'b1);
    send_point(CMD_STEP, 32'h0000_0005, 32'h0000_0000, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b1);
    // A row of one column is closed by its boundary step.
    send_point(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

    // Random phases, each under a fresh weight set written while the block is idle.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      drain_results();
      program_weights(random_weights());
      phase_end = items_sent + $urandom_range(60, 200);
      if (phase_end > target) begin
        phase_end = target;
      end
      while (items_sent < phase_end) begin
        random_row();
      end
    end

    // One full-length row with no idling at all, closed by the last column of the store.
    drain_results();
    program_weights(random_weights());
    if (gen_col != 0) begin
      send_point(CMD_LOAD, rand_sample(), rand_sample(), 1'b1);
    end
    steady = 1'b1;
    for (int i = 0; i < ROW_LEN; i++) begin
      send_point($urandom_range(1) ? CMD_STEP : CMD_LOAD, rand_sample(), rand_sample(),
                 1'b0);
    end
    steady = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### advection_stencil_row_step.f
rtl/advs_pkg.sv
rtl/advs_ram.sv
rtl/advs_front.sv
rtl/advs_queue.sv
rtl/advs_back.sv
rtl/advection_stencil_row_step.sv
tb/testbench.sv
